@@ hw/rtl/msd_pkg.sv @@
// Shared types and constants for the multichannel stereo downmix.
// Used by the mix datapath and the top level; no dependencies.
package msd_pkg;

  localparam int CFG_W = 7;

  localparam int GAIN_0707  = 23170;
  localparam int GAIN_SHIFT = 15;

  localparam int POS_FL = 0;
  localparam int POS_FR = 1;
  localparam int POS_C  = 2;
  localparam int POS_SL = 4;
  localparam int POS_SR = 5;

  typedef enum logic [1:0] {
    MODE_OFF,
    MODE_MONO,
    MODE_STEREO,
    MODE_MIX
  } mode_t;

  typedef struct packed {
    logic [1:0] n_res;
    logic       right0;
    logic       last0;
  } mix_ctl_t;

endpackage

@@ hw/rtl/msd_mix.sv @@
// Combinational downmix step: gain, accumulation, saturation and position update.
// Depends on msd_pkg.
module msd_mix import msd_pkg::*; #(
  parameter int SB    = 24,
  parameter int CW    = 7,
  parameter int ACC_W = 31
) (
  input  mode_t                   mode,
  input  logic [CW-1:0]           n_eff,
  input  logic [CW-1:0]           pos,
  input  logic signed [SB-1:0]    x,
  input  logic signed [ACC_W-1:0] left_sum,
  input  logic signed [ACC_W-1:0] right_sum,
  output logic signed [ACC_W-1:0] left_sum_next,
  output logic signed [ACC_W-1:0] right_sum_next,
  output logic [CW-1:0]           pos_next,
  output mix_ctl_t                ctl,
  output logic [SB-1:0]           res0,
  output logic [SB-1:0]           res1
);

  localparam logic signed [ACC_W-1:0] SAT_MAX = {{(ACC_W-SB+1){1'b0}}, {(SB-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] SAT_MIN = {{(ACC_W-SB+1){1'b1}}, {(SB-1){1'b0}}};

  logic signed [SB+15:0]    x_w;
  logic signed [SB+15:0]    gain_w;
  logic signed [SB+15:0]    prod;
  logic signed [SB-1:0]     c_sb;
  logic signed [SB-1:0]     h_sb;
  logic signed [ACC_W-1:0]  x_a;
  logic signed [ACC_W-1:0]  c_a;
  logic signed [ACC_W-1:0]  h_a;
  logic signed [ACC_W-1:0]  add_l;
  logic signed [ACC_W-1:0]  add_r;
  logic signed [ACC_W-1:0]  tot_l;
  logic signed [ACC_W-1:0]  tot_r;
  logic                     frame_end;

  function automatic logic signed [SB-1:0] sat(input logic signed [ACC_W-1:0] v);
    if (v > SAT_MAX) begin
      return SB'(SAT_MAX);
    end else if (v < SAT_MIN) begin
      return SB'(SAT_MIN);
    end
    return SB'(v);
  endfunction

  assign x_w    = {{16{x[SB-1]}}, x};
  assign gain_w = (SB+16)'(GAIN_0707);
  assign prod   = x_w * gain_w;
  assign c_sb   = prod[SB-1+GAIN_SHIFT:GAIN_SHIFT];
  assign h_sb   = x >>> 1;

  assign x_a = {{(ACC_W-SB){x[SB-1]}}, x};
  assign c_a = {{(ACC_W-SB){c_sb[SB-1]}}, c_sb};
  assign h_a = {{(ACC_W-SB){h_sb[SB-1]}}, h_sb};

  always_comb begin
    case (pos)
      CW'(POS_FL): begin
        add_l = x_a;
        add_r = '0;
      end
      CW'(POS_FR): begin
        add_l = '0;
        add_r = x_a;
      end
      CW'(POS_C): begin
        add_l = c_a;
        add_r = c_a;
      end
      CW'(POS_SL): begin
        add_l = c_a;
        add_r = '0;
      end
      CW'(POS_SR): begin
        add_l = '0;
        add_r = c_a;
      end
      default: begin
        add_l = h_a;
        add_r = h_a;
      end
    endcase
  end

  assign tot_l     = left_sum + add_l;
  assign tot_r     = right_sum + add_r;
  assign frame_end = ((CW+1)'(pos) + (CW+1)'(1)) >= (CW+1)'(n_eff);

  always_comb begin
    left_sum_next  = left_sum;
    right_sum_next = right_sum;
    pos_next       = pos;
    ctl            = '0;
    res0           = x;
    res1           = x;
    unique case (mode)
      MODE_OFF: begin
        ctl.n_res = 2'd0;
      end
      MODE_MONO: begin
        ctl.n_res = 2'd2;
        pos_next  = '0;
      end
      MODE_STEREO: begin
        ctl.n_res  = 2'd1;
        ctl.right0 = pos[0];
        ctl.last0  = 1'b1;
        pos_next   = pos[0] ? '0 : CW'(1);
      end
      MODE_MIX: begin
        if (frame_end) begin
          ctl.n_res      = 2'd2;
          res0           = sat(tot_l);
          res1           = sat(tot_r);
          left_sum_next  = '0;
          right_sum_next = '0;
          pos_next       = '0;
        end else begin
          left_sum_next  = tot_l;
          right_sum_next = tot_r;
          pos_next       = pos + CW'(1);
        end
      end
      default: begin
        ctl.n_res = 2'd0;
      end
    endcase
  end

endmodule

@@ hw/rtl/msd_out_buf.sv @@
// Two-entry result buffer that takes up to two beats at once and gives one per cycle
// while out_ready is high. No package dependencies.
module msd_out_buf #(
  parameter int W = 26
) (
  input  logic         clk,
  input  logic         rst,
  input  logic [1:0]   push_n,
  input  logic [W-1:0] d0,
  input  logic [W-1:0] d1,
  output logic [1:0]   free,
  output logic         out_valid,
  input  logic         out_ready,
  output logic [W-1:0] head
);

  logic [W-1:0] slot [2];
  logic [W-1:0] slot_next [2];
  logic [1:0]   count;
  logic [1:0]   count_next;
  logic [1:0]   kept;
  logic         pop;

  assign out_valid = count != 2'd0;
  assign pop       = out_valid && out_ready;
  assign kept      = count - {1'b0, pop};
  assign free      = 2'd2 - kept;
  assign head      = slot[0];

  always_comb begin
    slot_next[0] = pop ? slot[1] : slot[0];
    slot_next[1] = slot[1];
    if (push_n != 2'd0) begin
      if (kept == 2'd0) begin
        slot_next[0] = d0;
        if (push_n == 2'd2) begin
          slot_next[1] = d1;
        end
      end else begin
        slot_next[1] = d0;
      end
    end
    count_next = kept + push_n;
  end

  always_ff @(posedge clk) begin
    slot[0] <= slot_next[0];
    slot[1] <= slot_next[1];
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

endmodule

@@ hw/rtl/multichannel_stereo_downmix_top.sv @@
// Top level of the multichannel to stereo downmix: input register, frame state, result buffer.
// Depends on msd_pkg, msd_mix and msd_out_buf.
//
//   channel | handshake            | payload
//   --------+----------------------+----------------------------------
//   cfg     | cfg_valid, cfg_ready | cfg_data (channel count)
//   in      | in_valid, in_ready   | sample_in
//   out     | out_valid, out_ready | sample_out, is_right, last_of_run
//
// A sample beat is registered, then mixed into the frame sums once the result buffer has room.
// Stereo and downmix modes take one beat per cycle while the output does not stall; mono
// pushes two results per beat through the single output port and so takes beats more slowly.
// Reset sets the channel count to two and clears the sums; a config write clears them too.
// An output stall backs up through the two-entry result buffer into the input register.
module multichannel_stereo_downmix_top import msd_pkg::*; #(
  parameter int MAX_CHANNELS = 64,
  parameter int SAMPLE_BITS  = 24
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [CFG_W-1:0]              cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [SAMPLE_BITS-1:0] sample_in,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [SAMPLE_BITS-1:0] sample_out,
  output logic                          is_right,
  output logic                          last_of_run
);

  localparam int NBITS = $clog2(MAX_CHANNELS + 1);
  localparam int CW    = (CFG_W > NBITS) ? CFG_W : NBITS;
  localparam int ACC_W = SAMPLE_BITS + $clog2(MAX_CHANNELS) + 1;
  localparam int OW    = SAMPLE_BITS + 2;

  logic [CFG_W-1:0]              channel_count;
  logic                          s1_valid;
  logic signed [SAMPLE_BITS-1:0] s1_sample;
  logic signed [ACC_W-1:0]       left_sum;
  logic signed [ACC_W-1:0]       right_sum;
  logic [CW-1:0]                 pos;

  logic [CW-1:0]                 cnt_w;
  logic [CW-1:0]                 n_eff;
  mode_t                         mode;
  logic signed [ACC_W-1:0]       left_sum_next;
  logic signed [ACC_W-1:0]       right_sum_next;
  logic [CW-1:0]                 pos_next;
  mix_ctl_t                      ctl;
  logic [SAMPLE_BITS-1:0]        res0;
  logic [SAMPLE_BITS-1:0]        res1;
  logic [1:0]                    free;
  logic                          advance;
  logic [1:0]                    push_n;
  logic [OW-1:0]                 d0;
  logic [OW-1:0]                 d1;
  logic [OW-1:0]                 head;
  logic                          cfg_wr;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  assign cnt_w = CW'(channel_count);
  assign n_eff = (cnt_w > CW'(MAX_CHANNELS)) ? CW'(MAX_CHANNELS) : cnt_w;

  always_comb begin
    if (n_eff == CW'(0)) begin
      mode = MODE_OFF;
    end else if (n_eff == CW'(1)) begin
      mode = MODE_MONO;
    end else if (n_eff == CW'(2)) begin
      mode = MODE_STEREO;
    end else begin
      mode = MODE_MIX;
    end
  end

  msd_mix #(
    .SB    (SAMPLE_BITS),
    .CW    (CW),
    .ACC_W (ACC_W)
  ) u_mix (
    .mode           (mode),
    .n_eff          (n_eff),
    .pos            (pos),
    .x              (s1_sample),
    .left_sum       (left_sum),
    .right_sum      (right_sum),
    .left_sum_next  (left_sum_next),
    .right_sum_next (right_sum_next),
    .pos_next       (pos_next),
    .ctl            (ctl),
    .res0           (res0),
    .res1           (res1)
  );

  assign advance  = s1_valid && (ctl.n_res <= free);
  assign in_ready = !s1_valid || advance;
  assign push_n   = advance ? ctl.n_res : 2'd0;
  assign d0       = {res0, ctl.right0, ctl.last0};
  assign d1       = {res1, 1'b1, 1'b1};

  msd_out_buf #(
    .W (OW)
  ) u_out (
    .clk       (clk),
    .rst       (rst),
    .push_n    (push_n),
    .d0        (d0),
    .d1        (d1),
    .free      (free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .head      (head)
  );

  assign sample_out  = head[OW-1:2];
  assign is_right    = head[1];
  assign last_of_run = head[0];

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_sample <= sample_in;
    end
    if (rst) begin
      channel_count <= CFG_W'(2);
      s1_valid      <= 1'b0;
      left_sum      <= '0;
      right_sum     <= '0;
      pos           <= '0;
    end else begin
      if (in_ready) begin
        s1_valid <= in_valid;
      end
      if (cfg_wr) begin
        channel_count <= cfg_data;
        left_sum      <= '0;
        right_sum     <= '0;
        pos           <= '0;
      end else if (advance) begin
        left_sum  <= left_sum_next;
        right_sum <= right_sum_next;
        pos       <= pos_next;
      end
    end
  end

endmodule
